// ===== src/dfspf_pkg.sv =====
// ---------------------------------------------------------------------------
// dfspf_pkg - shared constants for the depth-first path finder
// Port widths, command codes and register indexes.
// ---------------------------------------------------------------------------
`default_nettype none

package dfspf_pkg;

   localparam int DEF_MAX_VERTICES = 64;

   localparam int VTX_W   = 7;   // vertex fields on the ports
   localparam int CNT_W   = 7;   // path count field
   localparam int CSR_W   = 7;   // widest register
   localparam int CSR_IDX_W = 2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic MODE_COUNT = 1'b0;
   localparam logic MODE_DFS   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE         = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_VERTEX_COUNT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_VERTEX = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_VERTEX = 2'd3;

endpackage

`default_nettype wire

// ===== src/dfspf_ram.sv =====
// ---------------------------------------------------------------------------
// dfspf_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds without re.
// ---------------------------------------------------------------------------
`default_nettype none

module dfspf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ===== src/dfs_path_finder.sv =====
// ---------------------------------------------------------------------------
// dfs_path_finder - adjacency matrix load, length-two path count, DFS path
// Loads an adjacency bit matrix one entry per transfer, then answers a query
// by counting two-hop paths or by walking a depth-first search to the target.
// ---------------------------------------------------------------------------
//  Channel | Ports                               | Dir | Moves
//  req     | req_valid/ready, cmd,row,col,edge   | in  | load entry or query
//  rsp     | rsp_valid/ready, vertex,count,last  | out | one path vertex/count
//  csr     | csr_we, csr_index, csr_wdata        | in  | register write
//
//  Loads are accepted back to back. In count mode a query reads two adjacency
//  bits per vertex; in DFS mode it tests adjacency bits, pops, walks the path
//  back through the parent RAM and emits its vertices, each step waiting on a
//  registered read of a single-read-port RAM. Reset clears control state only;
//  the adjacency RAM is undefined until loaded. A stalled rsp holds emission.
// ---------------------------------------------------------------------------
`default_nettype none

module dfs_path_finder
   import dfspf_pkg::*;
#(
   parameter int MAX_VERTICES = DEF_MAX_VERTICES
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_cmd,
   input  wire logic [VTX_W-1:0]     req_row,
   input  wire logic [VTX_W-1:0]     req_col,
   input  wire logic                 req_edge_req,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [VTX_W-1:0]          rsp_vertex,
   output logic [CNT_W-1:0]          rsp_path_count,
   output logic                      rsp_last,
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_W-1:0]     csr_wdata
);

   localparam int IW = $clog2(MAX_VERTICES);        // store index
   localparam int VW = $clog2(MAX_VERTICES + 1);    // vertex number 0..MAX
   localparam int CW = $clog2(MAX_VERTICES + 2);    // scan position 1..MAX+1
   localparam int SW = VW + CW;                     // stack entry
   localparam int ADJ_DEPTH = 1 << (2 * IW);
   localparam int STK_DEPTH = 1 << IW;

   typedef enum logic [11:0] {
      ST_IDLE      = 12'b000000000001,
      ST_CNT_A     = 12'b000000000010,
      ST_CNT_B     = 12'b000000000100,
      ST_CNT_C     = 12'b000000001000,
      ST_SCAN_RD   = 12'b000000010000,
      ST_SCAN_CHK  = 12'b000000100000,
      ST_POP_WAIT  = 12'b000001000000,
      ST_WALK_WR   = 12'b000010000000,
      ST_WALK_WAIT = 12'b000100000000,
      ST_EMIT_RD   = 12'b001000000000,
      ST_EMIT_OUT  = 12'b010000000000,
      ST_EMIT_ONE  = 12'b100000000000
   } state_type;

   // registers
   state_type          state_ff, state_in;
   logic               mode_ff;
   logic [CSR_W-1:0]   vcount_ff, start_ff, target_ff;
   logic [VW-1:0]      n_ff, n_in, s_ff, s_in, t_ff, t_in;
   logic [VW-1:0]      top_ff, top_in;
   logic [CW-1:0]      scan_ff, scan_in;
   logic [VW-1:0]      sp_ff, sp_in;
   logic [VW-1:0]      cnt_ff, cnt_in;
   logic               bit_a_ff, bit_a_in;
   logic [MAX_VERTICES-1:0] visited_ff, visited_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [VW-1:0]      rsp_vertex_ff, rsp_vertex_in;
   logic [VW-1:0]      rsp_count_ff, rsp_count_in;
   logic               rsp_last_ff, rsp_last_in;

   // RAM ports
   logic               adj_we, adj_re, adj_rdata;
   logic [2*IW-1:0]    adj_waddr, adj_raddr;
   logic               par_we, par_re;
   logic [IW-1:0]      par_waddr, par_raddr;
   logic [VW-1:0]      par_rdata;
   logic               stk_we, stk_re;
   logic [IW-1:0]      stk_waddr, stk_raddr;
   logic [SW-1:0]      stk_wdata, stk_rdata;

   logic               req_xfer, can_emit, row_ok, col_ok, range_ok;
   logic [VW-1:0]      n_use;
   logic [IW-1:0]      scan_idx;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_xfer  = req_valid && req_ready;
   assign can_emit  = !rsp_valid_ff || rsp_ready;
   assign scan_idx  = IW'(scan_ff - CW'(1));

   assign row_ok = (int'(req_row) >= 1) && (int'(req_row) <= MAX_VERTICES);
   assign col_ok = (int'(req_col) >= 1) && (int'(req_col) <= MAX_VERTICES);
   assign n_use  = (int'(vcount_ff) > MAX_VERTICES) ? VW'(MAX_VERTICES) : VW'(vcount_ff);
   assign range_ok = (int'(start_ff) >= 1) && (int'(start_ff) <= int'(n_use))
                  && (int'(target_ff) >= 1) && (int'(target_ff) <= int'(n_use));

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_COUNT;
         vcount_ff <= CSR_W'(1);
         start_ff  <= CSR_W'(1);
         target_ff <= CSR_W'(1);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MODE:          mode_ff   <= csr_wdata[0];
            CSR_VERTEX_COUNT:  vcount_ff <= csr_wdata;
            CSR_START_VERTEX:  start_ff  <= csr_wdata;
            CSR_TARGET_VERTEX: target_ff <= csr_wdata;
            default:           mode_ff   <= mode_ff;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      s_in          = s_ff;
      t_in          = t_ff;
      top_in        = top_ff;
      scan_in       = scan_ff;
      sp_in         = sp_ff;
      cnt_in        = cnt_ff;
      bit_a_in      = bit_a_ff;
      visited_in    = visited_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_vertex_in = rsp_vertex_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_last_in   = rsp_last_ff;

      adj_we    = 1'b0;
      adj_waddr = {IW'(req_row - VTX_W'(1)), IW'(req_col - VTX_W'(1))};
      adj_re    = 1'b0;
      adj_raddr = {IW'(top_ff - VW'(1)), scan_idx};
      par_we    = 1'b0;
      par_waddr = scan_idx;
      par_re    = 1'b0;
      par_raddr = IW'(top_ff - VW'(1));
      stk_we    = 1'b0;
      stk_waddr = IW'(sp_ff);
      stk_wdata = {top_ff, scan_ff + CW'(1)};
      stk_re    = 1'b0;
      stk_raddr = IW'(sp_ff - VW'(1));

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               if (req_cmd == CMD_LOAD) begin
                  adj_we = row_ok && col_ok;
               end else begin
                  n_in       = n_use;
                  s_in       = VW'(start_ff);
                  t_in       = VW'(target_ff);
                  visited_in = '0;
                  cnt_in     = '0;
                  scan_in    = CW'(1);
                  top_in     = VW'(start_ff);
                  sp_in      = '0;
                  if (!range_ok) begin
                     state_in = ST_EMIT_ONE;
                  end else if (mode_ff == MODE_COUNT) begin
                     state_in = ST_CNT_A;
                  end else if (start_ff == target_ff) begin
                     state_in = ST_EMIT_ONE;
                  end else begin
                     visited_in[IW'(start_ff - CSR_W'(1))] = 1'b1;
                     state_in = ST_SCAN_RD;
                  end
               end
            end
         end
         ST_CNT_A: begin
            adj_re    = 1'b1;
            adj_raddr = {IW'(s_ff - VW'(1)), scan_idx};
            state_in  = ST_CNT_B;
         end
         ST_CNT_B: begin
            bit_a_in  = adj_rdata;
            adj_re    = 1'b1;
            adj_raddr = {scan_idx, IW'(t_ff - VW'(1))};
            state_in  = ST_CNT_C;
         end
         ST_CNT_C: begin
            if (bit_a_ff && adj_rdata) begin
               cnt_in = cnt_ff + VW'(1);
            end
            if (scan_ff == CW'(n_ff)) begin
               state_in = ST_EMIT_ONE;
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = ST_CNT_A;
            end
         end
         ST_SCAN_RD: begin
            if (scan_ff > CW'(n_ff)) begin
               // neighbors exhausted: pop, or give up at the bottom
               if (sp_ff == '0) begin
                  state_in = ST_EMIT_ONE;
               end else begin
                  stk_re   = 1'b1;
                  sp_in    = sp_ff - VW'(1);
                  state_in = ST_POP_WAIT;
               end
            end else begin
               adj_re   = 1'b1;
               state_in = ST_SCAN_CHK;
            end
         end
         ST_SCAN_CHK: begin
            if (adj_rdata && !visited_ff[scan_idx]) begin
               par_we               = 1'b1;
               visited_in[scan_idx] = 1'b1;
               if (VW'(scan_ff) == t_ff) begin
                  top_in   = t_ff;
                  sp_in    = '0;
                  state_in = ST_WALK_WR;
               end else begin
                  stk_we   = 1'b1;
                  sp_in    = sp_ff + VW'(1);
                  top_in   = VW'(scan_ff);
                  scan_in  = CW'(1);
                  state_in = ST_SCAN_RD;
               end
            end else begin
               scan_in  = scan_ff + CW'(1);
               state_in = ST_SCAN_RD;
            end
         end
         ST_POP_WAIT: begin
            top_in   = stk_rdata[SW-1:CW];
            scan_in  = stk_rdata[CW-1:0];
            state_in = ST_SCAN_RD;
         end
         ST_WALK_WR: begin
            // record target-first path in the stack RAM, sp indexes each entry
            stk_we    = 1'b1;
            stk_waddr = IW'(sp_ff);
            stk_wdata = {top_ff, CW'(0)};
            if (top_ff == s_ff) begin
               state_in = ST_EMIT_RD;
            end else begin
               par_re   = 1'b1;
               sp_in    = sp_ff + VW'(1);
               state_in = ST_WALK_WAIT;
            end
         end
         ST_WALK_WAIT: begin
            top_in   = par_rdata;
            state_in = ST_WALK_WR;
         end
         ST_EMIT_RD: begin
            stk_re    = 1'b1;
            stk_raddr = IW'(sp_ff);
            state_in  = ST_EMIT_OUT;
         end
         ST_EMIT_OUT: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = stk_rdata[SW-1:CW];
               rsp_count_in  = '0;
               rsp_last_in   = (sp_ff == '0);
               if (sp_ff == '0) begin
                  state_in = ST_IDLE;
               end else begin
                  sp_in    = sp_ff - VW'(1);
                  state_in = ST_EMIT_RD;
               end
            end
         end
         ST_EMIT_ONE: begin
            if (can_emit) begin
               rsp_valid_in  = 1'b1;
               rsp_vertex_in = '0;
               rsp_count_in  = cnt_ff;
               rsp_last_in   = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         visited_ff   <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         visited_ff   <= visited_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff          <= n_in;
      s_ff          <= s_in;
      t_ff          <= t_in;
      top_ff        <= top_in;
      scan_ff       <= scan_in;
      sp_ff         <= sp_in;
      cnt_ff        <= cnt_in;
      bit_a_ff      <= bit_a_in;
      rsp_vertex_ff <= rsp_vertex_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_last_ff   <= rsp_last_in;
   end

   dfspf_ram #(.WIDTH(1), .DEPTH(ADJ_DEPTH)) u_adj_ram (
      .clock (clock),
      .we    (adj_we),
      .waddr (adj_waddr),
      .wdata (req_edge_req),
      .re    (adj_re),
      .raddr (adj_raddr),
      .rdata (adj_rdata)
   );

   dfspf_ram #(.WIDTH(VW), .DEPTH(STK_DEPTH)) u_parent_ram (
      .clock (clock),
      .we    (par_we),
      .waddr (par_waddr),
      .wdata (top_ff),
      .re    (par_re),
      .raddr (par_raddr),
      .rdata (par_rdata)
   );

   dfspf_ram #(.WIDTH(SW), .DEPTH(STK_DEPTH)) u_stack_ram (
      .clock (clock),
      .we    (stk_we),
      .waddr (stk_waddr),
      .wdata (stk_wdata),
      .re    (stk_re),
      .raddr (stk_raddr),
      .rdata (stk_rdata)
   );

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_vertex     = VTX_W'(rsp_vertex_ff);
   assign rsp_path_count = CNT_W'(rsp_count_ff);
   assign rsp_last       = rsp_last_ff;

endmodule

`default_nettype wire
